FILE: hdl/rshs_pkg.sv
// shared types and constants of the range sensor health supervisor
// no dependencies: every other file of the block takes its names from here
package rshs_pkg;

  // item kinds
  localparam logic [1:0] KIND_BRINGUP = 2'd0;
  localparam logic [1:0] KIND_POLL    = 2'd1;
  localparam logic [1:0] KIND_FILL    = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_BACKOFF = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_DIST    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_MS      = 8'd3;

  // field widths
  localparam int NOW_W     = 48;
  localparam int DIST_W    = 16;
  localparam int COUNT_W   = 8;
  localparam int MS_W      = 16;
  localparam int STALE_US_W = 26;  // 65535 ms in us fits 26 bits
  localparam int SLOTS     = 3;    // distance slots in a report

  localparam logic [9:0] MS_TO_US = 10'd1000;

  // register reset values
  localparam logic [NOW_W-1:0]      BACKOFF_RST  = 48'd1000000;
  localparam logic [COUNT_W-1:0]    LIMIT_RST    = 8'd3;
  localparam logic [DIST_W-1:0]     ERR_DIST_RST = 16'hFFFF;
  localparam logic [MS_W-1:0]       STALE_MS_RST = 16'd100;
  localparam logic [STALE_US_W-1:0] STALE_US_RST = 26'd100000;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 8'hFF;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        sensor;
    logic [NOW_W-1:0]  now_us;
    logic              start_ok;
    logic              query_ok;
    logic              data_ready;
    logic              read_ok;
    logic [DIST_W-1:0] distance_mm;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
    logic [DIST_W-1:0] dist_c;
    logic [SLOTS-1:0]  stale_mask;
    logic              sensor_up;
    logic              started;
    logic              forced_down;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;   // capture the accepted item
    logic commit;  // apply the item to sensor state and load the result
  } cmd_t;

endpackage

FILE: hdl/rshs_in_if.sv
// input channel of the supervisor: valid, ready and one item
// depends on rshs_pkg
interface rshs_in_if;
  logic                valid;
  logic                ready;
  rshs_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/rshs_out_if.sv
// result channel of the supervisor: valid, ready and one result item
// depends on rshs_pkg
interface rshs_out_if;
  logic                valid;
  logic                ready;
  rshs_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/rshs_cfg_if.sv
// configuration write channel: register index and write data
// depends on rshs_pkg
interface rshs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rshs_pkg::CFG_IDX_W-1:0]     index;
  logic [rshs_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/range_sensor_health_supervisor_top.sv
// timing: an accepted item is captured, committed in state EXEC, and its result
//   is presented in state SEND; the controller captures then commits each item,
//   and the next item is taken while a result waits
// reset: synchronous active-low rst_n; sensors down, counts and times zero,
//   config registers back to their default values
module range_sensor_health_supervisor_top #(
  parameter int SENSOR_COUNT = 3,
  parameter int TIME_BITS    = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  rshs_in_if.sink   in_ch,
  rshs_out_if.source out_ch,
  rshs_cfg_if.sink  cfg_ch
);

  rshs_pkg::cmd_t cmd;

  // config writes are to be made only while idle, which the block itself does not enforce; the port never stalls
  assign cfg_ch.ready = 1'b1;

  // controller: capture item, commit it, hand the result on
  rshs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: sensor health state, config and the result register
  rshs_datapath #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .TIME_BITS    (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_ch.payload),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .result    (out_ch.payload)
  );

endmodule

FILE: hdl/rshs_ctrl.sv
// controller of the supervisor: sequences accept, commit and result hand-off
// depends on rshs_pkg
module rshs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rshs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SEND = 4'b0100,
    S_PEND = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready   = (state_r == S_IDLE) || (state_r == S_SEND);
  assign out_valid  = (state_r == S_SEND) || (state_r == S_PEND);
  assign accept     = in_valid && in_ready;
  assign cmd.latch  = accept;
  assign cmd.commit = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_SEND;
      S_SEND: begin
        if (accept && out_ready)  state_nxt = S_EXEC;
        else if (accept)          state_nxt = S_PEND;
        else if (out_ready)       state_nxt = S_IDLE;
      end
      S_PEND: if (out_ready) state_nxt = S_EXEC;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: hdl/rshs_datapath.sv
// datapath of the supervisor: config registers, per-sensor state, result register
// depends on rshs_pkg
module rshs_datapath #(
  parameter int SENSOR_COUNT = 3,
  parameter int TIME_BITS    = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rshs_pkg::cmd_t                  cmd,
  input  rshs_pkg::in_item_t              in_item,
  input  logic                            cfg_we,
  input  logic [rshs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rshs_pkg::CFG_DATA_W-1:0] cfg_data,
  output rshs_pkg::out_item_t             result
);

  localparam int NW  = rshs_pkg::NOW_W;
  localparam int DW  = rshs_pkg::DIST_W;
  localparam int CW  = rshs_pkg::COUNT_W;
  localparam int LW  = rshs_pkg::STALE_US_W;

  // configuration
  logic [NW-1:0] backoff_r;
  logic [CW-1:0] limit_r;
  logic [DW-1:0] err_dist_r;
  logic [LW-1:0] stale_us_r;

  // sensor state
  logic                 up_r       [SENSOR_COUNT];
  logic [CW-1:0]        fail_r     [SENSOR_COUNT];
  logic [TIME_BITS-1:0] retry_t_r  [SENSOR_COUNT];
  logic [DW-1:0]        dist_r     [SENSOR_COUNT];
  logic [TIME_BITS-1:0] sample_t_r [SENSOR_COUNT];
  logic                 valid_r    [SENSOR_COUNT];
  logic                 sampled_r  [SENSOR_COUNT];

  logic                 up_nxt       [SENSOR_COUNT];
  logic [CW-1:0]        fail_nxt     [SENSOR_COUNT];
  logic [TIME_BITS-1:0] retry_t_nxt  [SENSOR_COUNT];
  logic [DW-1:0]        dist_nxt     [SENSOR_COUNT];
  logic [TIME_BITS-1:0] sample_t_nxt [SENSOR_COUNT];
  logic                 valid_nxt    [SENSOR_COUNT];
  logic                 sampled_nxt  [SENSOR_COUNT];

  rshs_pkg::in_item_t  item_r;
  rshs_pkg::out_item_t result_r, result_nxt;

  logic [TIME_BITS+NW-1:0] now_ext;
  logic [TIME_BITS-1:0]    now;
  logic [TIME_BITS-1:0]    stale_lim;
  logic                    is_fill;
  logic                    failed;
  logic [DW-1:0]           slot_dist [rshs_pkg::SLOTS];
  logic                    slot_good [rshs_pkg::SLOTS];

  // time taken modulo 2^TIME_BITS
  assign now_ext   = {{TIME_BITS{1'b0}}, item_r.now_us};
  assign now       = now_ext[TIME_BITS-1:0];
  assign stale_lim = {{(TIME_BITS-LW){1'b0}}, stale_us_r};
  assign is_fill   = (item_r.kind == rshs_pkg::KIND_FILL);
  assign failed    = !item_r.query_ok || (item_r.data_ready && !item_r.read_ok);

  // freshness of each report slot, missing slots always report the error code
  for (genvar g = 0; g < rshs_pkg::SLOTS; g++) begin : g_slot
    if (g < SENSOR_COUNT) begin : g_present
      logic [TIME_BITS-1:0] age;
      assign age          = now - sample_t_r[g];
      assign slot_good[g] = valid_r[g] && sampled_r[g] && (age <= stale_lim);
      assign slot_dist[g] = dist_r[g];
    end else begin : g_absent
      assign slot_good[g] = 1'b0;
      assign slot_dist[g] = err_dist_r;
    end
  end

  always_comb begin
    logic [TIME_BITS-1:0] retry_diff;
    logic [CW-1:0]        fail_inc;
    logic                 sel;
    result_nxt = '0;
    retry_diff = '0;
    fail_inc   = '0;
    sel        = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      up_nxt[i]       = up_r[i];
      fail_nxt[i]     = fail_r[i];
      retry_t_nxt[i]  = retry_t_r[i];
      dist_nxt[i]     = dist_r[i];
      sample_t_nxt[i] = sample_t_r[i];
      valid_nxt[i]    = valid_r[i];
      sampled_nxt[i]  = sampled_r[i];

      sel        = (item_r.sensor == 2'(i));
      retry_diff = now - retry_t_r[i];
      fail_inc   = (fail_r[i] == rshs_pkg::COUNT_MAX) ? rshs_pkg::COUNT_MAX
                                                      : fail_r[i] + 1'b1;

      if (sel && item_r.kind == rshs_pkg::KIND_BRINGUP) begin
        fail_nxt[i]       = '0;
        up_nxt[i]         = item_r.start_ok;
        result_nxt.started = 1'b1;
      end else if (sel && item_r.kind == rshs_pkg::KIND_POLL) begin
        if (!up_r[i]) begin
          // retry bring-up once the backoff has run out
          if ({{NW{1'b0}}, retry_diff} >= {{TIME_BITS{1'b0}}, backoff_r}) begin
            retry_t_nxt[i]     = now;
            fail_nxt[i]        = '0;
            up_nxt[i]          = item_r.start_ok;
            result_nxt.started = 1'b1;
          end
        end else if (failed) begin
          fail_nxt[i] = fail_inc;
          if (fail_inc >= limit_r) begin
            up_nxt[i]              = 1'b0;
            retry_t_nxt[i]         = now;
            result_nxt.forced_down = 1'b1;
          end
        end else if (item_r.data_ready) begin
          fail_nxt[i]     = '0;
          dist_nxt[i]     = item_r.distance_mm;
          sample_t_nxt[i] = now;
          sampled_nxt[i]  = 1'b1;
          valid_nxt[i]    = (item_r.distance_mm != err_dist_r);
        end
      end

      if (sel && up_nxt[i]) result_nxt.sensor_up = 1'b1;
    end

    if (is_fill) begin
      result_nxt.dist_a = slot_good[0] ? slot_dist[0] : err_dist_r;
      result_nxt.dist_b = slot_good[1] ? slot_dist[1] : err_dist_r;
      result_nxt.dist_c = slot_good[2] ? slot_dist[2] : err_dist_r;
      result_nxt.stale_mask = {!slot_good[2], !slot_good[1], !slot_good[0]};
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch)  item_r   <= in_item;
    if (cmd.commit) result_r <= result_nxt;
  end

  assign result = result_r;

  // configuration registers, stale limit kept in microseconds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r  <= rshs_pkg::BACKOFF_RST;
      limit_r    <= rshs_pkg::LIMIT_RST;
      err_dist_r <= rshs_pkg::ERR_DIST_RST;
      stale_us_r <= rshs_pkg::STALE_US_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rshs_pkg::CFG_RETRY_BACKOFF: backoff_r  <= cfg_data[NW-1:0];
        rshs_pkg::CFG_ERROR_LIMIT:   limit_r    <= cfg_data[CW-1:0];
        rshs_pkg::CFG_ERROR_DIST:    err_dist_r <= cfg_data[DW-1:0];
        rshs_pkg::CFG_STALE_MS:
          stale_us_r <= LW'(cfg_data[rshs_pkg::MS_W-1:0] * rshs_pkg::MS_TO_US);
        default: ;
      endcase
    end
  end

  // sensor state
  always_ff @(posedge clk) begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (!rst_n) begin
        up_r[i]       <= 1'b0;
        fail_r[i]     <= '0;
        retry_t_r[i]  <= '0;
        dist_r[i]     <= rshs_pkg::ERR_DIST_RST;
        sample_t_r[i] <= '0;
        valid_r[i]    <= 1'b0;
        sampled_r[i]  <= 1'b0;
      end else if (cmd.commit) begin
        up_r[i]       <= up_nxt[i];
        fail_r[i]     <= fail_nxt[i];
        retry_t_r[i]  <= retry_t_nxt[i];
        dist_r[i]     <= dist_nxt[i];
        sample_t_r[i] <= sample_t_nxt[i];
        valid_r[i]    <= valid_nxt[i];
        sampled_r[i]  <= sampled_nxt[i];
      end
    end
  end

endmodule
